// File: hw/rtl/fsb_pkg.sv
// shared types and constants for the friction smoothstep blend
package fsb_pkg;

   localparam int SPEED_W = 24;
   localparam int COEF_W  = 16;

   typedef enum logic [1:0] {
      MODE_STATIC  = 2'd0,
      MODE_KINETIC = 2'd1,
      MODE_BLEND   = 2'd2
   } mode_type;

   typedef struct packed {
      logic              valid;
      mode_type          mode;
      logic [COEF_W-1:0] static_coef;
      logic [COEF_W-1:0] kinetic_coef;
   } ctl_type;

endpackage

// File: hw/rtl/fsb_divider.sv
// pipelined restoring divider giving the transition fraction, one quotient bit per stage
module fsb_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsb_pkg::ctl_type              in_ctl,
   input  logic [fsb_pkg::SPEED_W-1:0]   in_rem,
   input  logic [fsb_pkg::SPEED_W-1:0]   in_width,
   input  logic                          in_full,
   output fsb_pkg::ctl_type              out_ctl,
   output logic [FRAC_BITS:0]            out_t
);

   localparam int W = fsb_pkg::SPEED_W;

   fsb_pkg::ctl_type     ctl_ff   [FRAC_BITS];
   logic [W-1:0]         rem_ff   [FRAC_BITS];
   logic [W-1:0]         width_ff [FRAC_BITS];
   logic                 full_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff     [FRAC_BITS];

   fsb_pkg::ctl_type     ctl_src   [FRAC_BITS];
   logic [W-1:0]         rem_src   [FRAC_BITS];
   logic [W-1:0]         width_src [FRAC_BITS];
   logic                 full_src  [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_src     [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
      logic [W:0]           shifted;
      logic                 take;
      fsb_pkg::ctl_type     ctl_in;
      logic [W-1:0]         rem_in;
      logic [FRAC_BITS-1:0] q_in;

      if (k == 0) begin : g_first
         assign ctl_src[k]   = in_ctl;
         assign rem_src[k]   = in_rem;
         assign width_src[k] = in_width;
         assign full_src[k]  = in_full;
         assign q_src[k]     = '0;
      end else begin : g_next
         assign ctl_src[k]   = ctl_ff[k-1];
         assign rem_src[k]   = rem_ff[k-1];
         assign width_src[k] = width_ff[k-1];
         assign full_src[k]  = full_ff[k-1];
         assign q_src[k]     = q_ff[k-1];
      end

      always_comb begin
         shifted = {rem_src[k], 1'b0};
         take    = shifted >= {1'b0, width_src[k]};
         rem_in  = take ? W'(shifted - {1'b0, width_src[k]}) : shifted[W-1:0];
         q_in    = {q_src[k][FRAC_BITS-2:0], take};
         ctl_in  = ctl_src[k];
         if (reset) begin
            ctl_in.valid = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         ctl_ff[k]   <= ctl_in;
         rem_ff[k]   <= rem_in;
         width_ff[k] <= width_src[k];
         full_ff[k]  <= full_src[k];
         q_ff[k]     <= q_in;
      end
   end

   assign out_ctl = ctl_ff[FRAC_BITS-1];
   assign out_t   = full_ff[FRAC_BITS-1] ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                         : {1'b0, q_ff[FRAC_BITS-1]};

endmodule

// File: hw/rtl/fsb_shaper.sv
// two stage smoothstep shaping of the fraction, 3t^2 - 2t^3
module fsb_shaper #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fsb_pkg::ctl_type     in_ctl,
   input  logic [FRAC_BITS:0]   in_t,
   output fsb_pkg::ctl_type     out_ctl,
   output logic [FRAC_BITS:0]   out_s
);

   localparam int F = FRAC_BITS;
   localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
   localparam logic [F+2:0] ONE_WIDE  = (F+3)'(1) << F;

   fsb_pkg::ctl_type ctl_a_ff, ctl_a_in, ctl_b_ff, ctl_b_in;
   logic [F:0]       t2_ff, t2_in;
   logic [F+1:0]     cubic_ff, cubic_in;
   logic [F:0]       s_ff, s_in;
   logic [2*F+1:0]   tsq;
   logic [2*F+2:0]   sprod;
   logic [F+2:0]     s_raw;

   // square and cubic factor
   always_comb begin
      tsq      = (2*F+2)'(in_t) * (2*F+2)'(in_t);
      t2_in    = tsq[2*F:F];
      cubic_in = THREE_ONE - {in_t, 1'b0};
      ctl_a_in = in_ctl;
      if (reset) begin
         ctl_a_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ctl_a_ff <= ctl_a_in;
      t2_ff    <= t2_in;
      cubic_ff <= cubic_in;
   end

   // shaped fraction, clamped to one
   always_comb begin
      sprod    = (2*F+3)'(t2_ff) * (2*F+3)'(cubic_ff);
      s_raw    = sprod[2*F+2:F];
      s_in     = (s_raw > ONE_WIDE) ? ONE_WIDE[F:0] : s_raw[F:0];
      ctl_b_in = ctl_a_ff;
      if (reset) begin
         ctl_b_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ctl_b_ff <= ctl_b_in;
      s_ff     <= s_in;
   end

   assign out_ctl = ctl_b_ff;
   assign out_s   = s_ff;

endmodule

// File: hw/rtl/fsb_blend.sv
// blend of static toward kinetic coefficient with round half up, pick by mode, and result register
module fsb_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fsb_pkg::ctl_type            in_ctl,
   input  logic [FRAC_BITS:0]          in_s,
   output logic                        out_valid,
   output logic [fsb_pkg::COEF_W-1:0]  out_coef
);

   localparam int F  = FRAC_BITS;
   localparam int CW = fsb_pkg::COEF_W;
   localparam int PW = CW + F + 3;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (F-1);

   fsb_pkg::ctl_type         ctl_ff, ctl_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [CW:0]       delta;
   logic signed [F+1:0]      s_sgn;
   logic signed [PW-1:0]     base;
   logic signed [PW-1:0]     sum;
   logic                     valid_ff, valid_in;
   logic [CW-1:0]            coef_ff, coef_in;

   // weighted difference
   always_comb begin
      delta   = $signed({1'b0, in_ctl.kinetic_coef}) - $signed({1'b0, in_ctl.static_coef});
      s_sgn   = $signed({1'b0, in_s});
      prod_in = PW'(delta) * PW'(s_sgn);
      ctl_in  = in_ctl;
      if (reset) begin
         ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      prod_ff <= prod_in;
   end

   // round, scale and pick by mode
   always_comb begin
      base = $signed({{(PW-CW-F){1'b0}}, ctl_ff.static_coef, {F{1'b0}}});
      sum  = base + prod_ff + HALF;
      case (ctl_ff.mode)
         fsb_pkg::MODE_STATIC:  coef_in = ctl_ff.static_coef;
         fsb_pkg::MODE_KINETIC: coef_in = ctl_ff.kinetic_coef;
         fsb_pkg::MODE_BLEND:   coef_in = sum[F+CW-1:F];
         default:               coef_in = ctl_ff.static_coef;
      endcase
      valid_in = ctl_ff.valid && !reset;
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      coef_ff  <= coef_in;
   end

   assign out_valid = valid_ff;
   assign out_coef  = coef_ff;

endmodule

// File: hw/rtl/friction_smoothstep_blend.sv
// top level of the friction smoothstep blend pipeline
// a word passes the input register, the divider stages, the shaper stages and the blend registers in that order
// throughput: one word per cycle while busy is low, set by the divider taking one quotient bit per stage
// busy is reset registered: it rises and falls in the cycle after reset does, and is low otherwise
// reset: synchronous, active high, clears every valid bit; no result is lost to back pressure
module friction_smoothstep_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [fsb_pkg::SPEED_W-1:0] req_speed,
   input  logic [fsb_pkg::SPEED_W-1:0] req_stick_speed,
   input  logic [fsb_pkg::SPEED_W-1:0] req_blend_width,
   input  logic [fsb_pkg::COEF_W-1:0]  req_static_coef,
   input  logic [fsb_pkg::COEF_W-1:0]  req_kinetic_coef,
   output logic                        rsp_valid,
   output logic [fsb_pkg::COEF_W-1:0]  rsp_friction_coef
);

   localparam int W   = fsb_pkg::SPEED_W;
   localparam int LAT = FRAC_BITS + 5;

   logic             busy_ff, busy_in;
   logic             accept;
   fsb_pkg::ctl_type ctl_ff, ctl_in;
   logic [W-1:0]     diff_ff, diff_in;
   logic [W-1:0]     width_ff;
   logic             full_ff, full_in;

   fsb_pkg::ctl_type div_ctl;
   logic [FRAC_BITS:0] div_t;
   fsb_pkg::ctl_type shp_ctl;
   logic [FRAC_BITS:0] shp_s;

   assign busy_in = reset;
   assign accept  = start && !busy_ff;

   // classify the word and form the dividend
   always_comb begin
      diff_in            = req_speed - req_stick_speed;
      full_in            = diff_in >= req_blend_width;
      ctl_in.valid       = accept && !reset;
      ctl_in.static_coef  = req_static_coef;
      ctl_in.kinetic_coef = req_kinetic_coef;
      if (req_speed < req_stick_speed) begin
         ctl_in.mode = fsb_pkg::MODE_STATIC;
      end else if (req_blend_width == '0) begin
         ctl_in.mode = fsb_pkg::MODE_KINETIC;
      end else begin
         ctl_in.mode = fsb_pkg::MODE_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      busy_ff  <= busy_in;
      ctl_ff   <= ctl_in;
      diff_ff  <= diff_in;
      width_ff <= req_blend_width;
      full_ff  <= full_in;
   end

   assign busy = busy_ff;

   fsb_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (ctl_ff),
      .in_rem   (diff_ff),
      .in_width (width_ff),
      .in_full  (full_ff),
      .out_ctl  (div_ctl),
      .out_t    (div_t)
   );

   fsb_shaper #(.FRAC_BITS(FRAC_BITS)) u_shaper (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (div_ctl),
      .in_t    (div_t),
      .out_ctl (shp_ctl),
      .out_s   (shp_s)
   );

   fsb_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (shp_ctl),
      .in_s      (shp_s),
      .out_valid (rsp_valid),
      .out_coef  (rsp_friction_coef)
   );

`ifndef ASSERT_OFF
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result strobe without an accepted word");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted word produced no result");

   a_static_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(accept && (req_speed < req_stick_speed), LAT))
      |-> (rsp_friction_coef == $past(req_static_coef, LAT)))
      else $error("speed below stick did not give the static coefficient");

   a_busy_reset_only: assert property (@(posedge clock)
      !$past(reset) |-> !busy)
      else $error("busy raised outside reset");
`endif

endmodule

// File: test/fsb_checker.sv
`timescale 1ns / 1ps
// checker for the friction blend: predicts each accepted word and compares each result
module fsb_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [fsb_pkg::SPEED_W-1:0] req_speed,
   input  logic [fsb_pkg::SPEED_W-1:0] req_stick_speed,
   input  logic [fsb_pkg::SPEED_W-1:0] req_blend_width,
   input  logic [fsb_pkg::COEF_W-1:0]  req_static_coef,
   input  logic [fsb_pkg::COEF_W-1:0]  req_kinetic_coef,
   input  logic                        rsp_valid,
   input  logic [fsb_pkg::COEF_W-1:0]  rsp_friction_coef,
   output int                          fail_count,
   output int                          pending,
   output int                          checked,
   output int                          blended
);

   localparam int SPEED_W = fsb_pkg::SPEED_W;
   localparam int COEF_W  = fsb_pkg::COEF_W;

   typedef struct {
      logic [COEF_W-1:0] coef;
      fsb_pkg::mode_type mode;
      int unsigned       seq;
   } coef_due_type;

   coef_due_type coef_due_q[$];
   int unsigned  words_seen = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      blended    = 0;
   end

   function automatic coef_due_type predict_friction(
      input logic [SPEED_W-1:0] speed,
      input logic [SPEED_W-1:0] stick,
      input logic [SPEED_W-1:0] width,
      input logic [COEF_W-1:0]  cs,
      input logic [COEF_W-1:0]  ck
   );
      logic [63:0]  one, diff, t, t2, s, mix;
      coef_due_type e;
      one   = 64'd1 << FRAC_BITS;
      e.seq = 0;
      if (speed < stick) begin
         e.mode = fsb_pkg::MODE_STATIC;
         e.coef = cs;
      end else if (width == '0) begin
         e.mode = fsb_pkg::MODE_KINETIC;
         e.coef = ck;
      end else begin
         e.mode = fsb_pkg::MODE_BLEND;
         diff   = {40'd0, speed} - {40'd0, stick};
         if (diff >= {40'd0, width}) begin
            t = one;
         end else begin
            t = (diff << FRAC_BITS) / {40'd0, width};
         end
         t2 = (t * t) >> FRAC_BITS;
         s  = (t2 * (3 * one - 2 * t)) >> FRAC_BITS;
         if (s > one) begin
            s = one;
         end
         mix    = {48'd0, cs} * (one - s) + {48'd0, ck} * s + (one >> 1);
         e.coef = mix[FRAC_BITS +: COEF_W];
      end
      return e;
   endfunction

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin : watch
      coef_due_type e;
      if (!reset && start && !busy) begin
         e     = predict_friction(req_speed, req_stick_speed, req_blend_width,
                                  req_static_coef, req_kinetic_coef);
         e.seq = words_seen;
         words_seen = words_seen + 1;
         coef_due_q.push_back(e);
      end
      if (!reset && rsp_valid) begin
         if (coef_due_q.size() == 0) begin
            report($sformatf("result 0x%04h with no word outstanding", rsp_friction_coef));
         end else begin
            e = coef_due_q.pop_front();
            checked = checked + 1;
            if (e.mode == fsb_pkg::MODE_BLEND) begin
               blended = blended + 1;
            end
            if (rsp_friction_coef !== e.coef) begin
               report($sformatf("word %0d (%s) friction_coef got 0x%04h expected 0x%04h",
                                e.seq, e.mode.name(), rsp_friction_coef, e.coef));
            end
         end
      end
      pending <= coef_due_q.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench top for the friction blend: bursty stimulus, verdict and watchdog
module tb;

   localparam int FRAC_BITS = 16;
   localparam int N_RANDOM  = 1450;
   localparam int SPEED_MAX = 24'hFFFFFF;
   localparam int SPEED_W   = fsb_pkg::SPEED_W;
   localparam int COEF_W    = fsb_pkg::COEF_W;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [SPEED_W-1:0] req_speed = '0;
   logic [SPEED_W-1:0] req_stick_speed = '0;
   logic [SPEED_W-1:0] req_blend_width = '0;
   logic [COEF_W-1:0]  req_static_coef = '0;
   logic [COEF_W-1:0]  req_kinetic_coef = '0;
   logic               rsp_valid;
   logic [COEF_W-1:0]  rsp_friction_coef;

   int fail_count, pending, checked, blended;
   int words_sent = 0;

   always #5 clock = ~clock;

   friction_smoothstep_blend #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_speed        (req_speed),
      .req_stick_speed  (req_stick_speed),
      .req_blend_width  (req_blend_width),
      .req_static_coef  (req_static_coef),
      .req_kinetic_coef (req_kinetic_coef),
      .rsp_valid        (rsp_valid),
      .rsp_friction_coef(rsp_friction_coef)
   );

   fsb_checker #(.FRAC_BITS(FRAC_BITS)) chk (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_speed        (req_speed),
      .req_stick_speed  (req_stick_speed),
      .req_blend_width  (req_blend_width),
      .req_static_coef  (req_static_coef),
      .req_kinetic_coef (req_kinetic_coef),
      .rsp_valid        (rsp_valid),
      .rsp_friction_coef(rsp_friction_coef),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked          (checked),
      .blended          (blended)
   );

   task automatic send_word(
      input logic [SPEED_W-1:0] sp,
      input logic [SPEED_W-1:0] st,
      input logic [SPEED_W-1:0] bw,
      input logic [COEF_W-1:0]  cs,
      input logic [COEF_W-1:0]  ck
   );
      start            <= 1'b1;
      req_speed        <= sp;
      req_stick_speed  <= st;
      req_blend_width  <= bw;
      req_static_coef  <= cs;
      req_kinetic_coef <= ck;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent = words_sent + 1;
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [COEF_W-1:0] rand_coef();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COEF_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // spread widths over every magnitude, zero included
   function automatic int unsigned rand_width();
      int unsigned b;
      b = $urandom_range(0, 24);
      if (b == 0) begin
         return 0;
      end
      return $urandom & ((32'd1 << b) - 1);
   endfunction

   initial begin
      int unsigned sp, st, bw, off;
      int          kind, burst_left, gap;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // speed below stick, zero width, at stick, clamped t, extremes
      send_word(24'd0, 24'd1, 24'd100, 16'hFFFF, 16'h0000);
      send_word(24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFF, 16'h1234, 16'hFFFF);
      send_word(24'd5, 24'd5, 24'd0, 16'hAAAA, 16'h5555);
      send_word(24'hFFFFFF, 24'd0, 24'd0, 16'h0000, 16'hFFFF);
      send_word(24'h010000, 24'h010000, 24'h008000, 16'hFFFF, 16'h0000);
      send_word(24'hFFFFFF, 24'd0, 24'd1, 16'hFFFF, 16'h0000);
      send_word(24'hFFFFFF, 24'd0, 24'hFFFFFF, 16'h0000, 16'hFFFF);
      pause(3);
      send_word(24'hFFFFFE, 24'd0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      send_word(24'h018000, 24'h010000, 24'h010000, 16'h1000, 16'h0800);
      send_word(24'd1, 24'd0, 24'hFFFFFF, 16'hFFFF, 16'h0000);
      send_word(24'd0, 24'd0, 24'd0, 16'h0000, 16'h0000);
      send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      pause(1);
      send_word(24'h004000, 24'd0, 24'h010000, 16'h3000, 16'h1800);
      send_word(24'h00C000, 24'd0, 24'h010000, 16'h0000, 16'hFFFF);
      send_word(24'd2, 24'd1, 24'd3, 16'hFFFF, 16'h0001);
      send_word(24'h800000, 24'h7FFFFF, 24'd2, 16'h8000, 16'h7FFF);
      send_word(24'h7FFFFF, 24'h800000, 24'd0, 16'h5555, 16'hAAAA);
      send_word(24'hFFFFFF, 24'h000001, 24'hFFFFFE, 16'hFFFF, 16'h0000);

      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 1) begin
            sp = $urandom & SPEED_MAX;
            st = $urandom & SPEED_MAX;
            bw = $urandom & SPEED_MAX;
         end else if (kind == 2) begin
            st = $urandom_range(1, SPEED_MAX);
            sp = $urandom_range(0, st - 1);
            bw = rand_width();
         end else if (kind == 3) begin
            sp = $urandom & SPEED_MAX;
            st = $urandom & SPEED_MAX;
            bw = 0;
         end else begin
            bw  = rand_width();
            st  = $urandom_range(0, SPEED_MAX - bw);
            off = (kind == 9) ? bw + $urandom_range(0, 4095) : $urandom_range(0, bw);
            sp  = st + off;
            if (sp > SPEED_MAX) begin
               sp = SPEED_MAX;
            end
         end
         send_word(sp[SPEED_W-1:0], st[SPEED_W-1:0], bw[SPEED_W-1:0],
                   rand_coef(), rand_coef());

         // a long stretch in the middle runs back to back
         if (i >= 600 && i < 800) begin
            gap = 0;
         end else if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
         end else begin
            gap        = 0;
            burst_left = burst_left - 1;
         end
         pause(gap);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (FRAC_BITS + 8) @(posedge clock);

      $display("%0d words sent, %0d results checked, %0d of them in the blend region",
               words_sent, checked, blended);
      $display("stimulus: directed edge cases, then random bursts with gaps and a back-to-back run");
      if (fail_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("watchdog expired with %0d results outstanding", pending);
      $display("Mismatches found");
      $finish;
   end

endmodule
